>>> hw/rtl/rbst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants of the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int WIDEN_W = 16;

    // quotient bits produced by the divider (one overflow guard bit)
    localparam int QBITS = 33;

    // divider pipeline stages: magnitude stage, setup stage, one stage per bit, sign stage
    localparam int DIV_LAT = QBITS + 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_ONLY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_WIDEN   = 1'd1;

    // reset values
    localparam logic               FORWARD_ONLY_RST = 1'b1;
    localparam logic [WIDEN_W-1:0] EXIT_WIDEN_RST   = 16'd1537;

    // saturation limits
    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

endpackage

>>> hw/rtl/ray_box_slab_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray against axis-aligned box slab test in signed fixed point.
// ----------------------------------------------------------------------------
// One request per clock enters and one result leaves per clock; a request
// passes from acceptance to its result through the input register, difference
// stage, a 36 stage bit-per-stage divider for each of the six slab planes,
// then ordering, entry/exit selection, magnitude, widening multiply and the
// output register. The whole pipeline holds while a result waits on m_ready.
module ray_box_slab_test
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [WIDEN_W-1:0]   cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  coord_t               s_origin_x,
    input  coord_t               s_origin_y,
    input  coord_t               s_origin_z,
    input  coord_t               s_dir_x,
    input  coord_t               s_dir_y,
    input  coord_t               s_dir_z,
    input  coord_t               s_box_min_x,
    input  coord_t               s_box_min_y,
    input  coord_t               s_box_min_z,
    input  coord_t               s_box_max_x,
    input  coord_t               s_box_max_y,
    input  coord_t               s_box_max_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output coord_t               m_t_entry,
    output coord_t               m_t_exit
);

    localparam int NSTG = DIV_LAT + 7;

    // configuration registers
    logic               forward_only_reg;
    logic [WIDEN_W-1:0] exit_widen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forward_only_reg <= FORWARD_ONLY_RST;
            exit_widen_reg   <= EXIT_WIDEN_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_FORWARD_ONLY: forward_only_reg <= cfg_data[0];
                CFG_EXIT_WIDEN:   exit_widen_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance and valid bits
    logic            en;
    logic [NSTG-1:0] vld_reg;

    assign en      = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    // input register
    coord_t org_reg [0:2];
    coord_t dir_reg [0:2];
    coord_t lo_reg  [0:2];
    coord_t hi_reg  [0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            org_reg[0] <= s_origin_x;
            org_reg[1] <= s_origin_y;
            org_reg[2] <= s_origin_z;
            dir_reg[0] <= s_dir_x;
            dir_reg[1] <= s_dir_y;
            dir_reg[2] <= s_dir_z;
            lo_reg[0]  <= s_box_min_x;
            lo_reg[1]  <= s_box_min_y;
            lo_reg[2]  <= s_box_min_z;
            hi_reg[0]  <= s_box_max_x;
            hi_reg[1]  <= s_box_max_y;
            hi_reg[2]  <= s_box_max_z;
        end
    end

    // per axis: differences, two dividers, ordering
    coord_t tmn_reg [0:2];
    coord_t tmx_reg [0:2];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        diff_t  dlo_reg;
        diff_t  dhi_reg;
        coord_t den_reg;
        coord_t t0;
        coord_t t1;

        always_ff @(posedge aclk) begin
            if (en) begin
                dlo_reg <= diff_t'(lo_reg[a]) - diff_t'(org_reg[a]);
                dhi_reg <= diff_t'(hi_reg[a]) - diff_t'(org_reg[a]);
                den_reg <= dir_reg[a];
            end
        end

        rbst_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
            .aclk (aclk),
            .en   (en),
            .num  (dlo_reg),
            .den  (den_reg),
            .quot (t0)
        );

        rbst_slab_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
            .aclk (aclk),
            .en   (en),
            .num  (dhi_reg),
            .den  (den_reg),
            .quot (t1)
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                tmn_reg[a] <= (t0 < t1) ? t0 : t1;
                tmx_reg[a] <= (t0 < t1) ? t1 : t0;
            end
        end
    end

    // entry is the largest minimum, exit the smallest maximum
    coord_t near_reg;
    coord_t far_reg;
    coord_t near_01;
    coord_t far_01;

    assign near_01 = (tmn_reg[1] > tmn_reg[0]) ? tmn_reg[1] : tmn_reg[0];
    assign far_01  = (tmx_reg[1] < tmx_reg[0]) ? tmx_reg[1] : tmx_reg[0];

    always_ff @(posedge aclk) begin
        if (en) begin
            near_reg <= (tmn_reg[2] > near_01) ? tmn_reg[2] : near_01;
            far_reg  <= (tmx_reg[2] < far_01) ? tmx_reg[2] : far_01;
        end
    end

    // exit magnitude
    coord_t             near_a_reg;
    coord_t             far_a_reg;
    logic [COORD_W-1:0] mag_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            near_a_reg <= near_reg;
            far_a_reg  <= far_reg;
            mag_reg    <= far_reg[COORD_W-1] ? COORD_W'(-far_reg) : COORD_W'(far_reg);
        end
    end

    // widening multiply, keep the part above 2^32
    localparam int PROD_W = COORD_W + WIDEN_W;
    logic [PROD_W-1:0]  prod;
    coord_t             near_m_reg;
    coord_t             far_m_reg;
    logic [WIDEN_W-1:0] extra_reg;

    assign prod = PROD_W'(mag_reg) * PROD_W'(exit_widen_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            near_m_reg <= near_a_reg;
            far_m_reg  <= far_a_reg;
            extra_reg  <= prod[PROD_W-1:COORD_W];
        end
    end

    // widened exit with saturation, hit rule
    diff_t  wide_sum;
    coord_t wide;
    logic   hit_next;

    always_comb begin
        if (far_m_reg[COORD_W-1]) begin
            wide_sum = diff_t'(far_m_reg) - diff_t'({1'b0, extra_reg});
        end else begin
            wide_sum = diff_t'(far_m_reg) + diff_t'({1'b0, extra_reg});
        end
        if (wide_sum > diff_t'(SAT_MAX)) begin
            wide = SAT_MAX;
        end else if (wide_sum < diff_t'(SAT_MIN)) begin
            wide = SAT_MIN;
        end else begin
            wide = coord_t'(wide_sum[COORD_W-1:0]);
        end
        if (forward_only_reg) begin
            hit_next = (far_m_reg > 0) && (near_m_reg < far_m_reg);
        end else begin
            hit_next = near_m_reg < wide;
        end
    end

    // output register
    logic   hit_reg;
    coord_t entry_reg;
    coord_t exit_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg   <= hit_next;
            entry_reg <= near_m_reg;
            exit_reg  <= wide;
        end
    end

    assign m_hit     = hit_reg;
    assign m_t_entry = entry_reg;
    assign m_t_exit  = exit_reg;

endmodule

>>> hw/rtl/rbst_slab_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbst_slab_div
// Pipelined signed fixed point divider, one quotient bit per stage,
// saturating to 32 bits; a zero divisor saturates with the numerator sign.
// ----------------------------------------------------------------------------
module rbst_slab_div
    import rbst_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic   aclk,
    input  logic   en,
    input  diff_t  num,
    input  coord_t den,
    output coord_t quot
);

    // magnitude stage
    logic [DIFF_W-1:0]  mn_reg;
    logic [COORD_W-1:0] md_reg;
    logic               neg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mn_reg  <= num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
            md_reg  <= den[COORD_W-1] ? COORD_W'(-den) : COORD_W'(den);
            neg_reg <= num[DIFF_W-1] != den[COORD_W-1];
        end
    end

    // per-stage pipeline registers, index 0 is the setup stage
    logic [COORD_W-1:0] rem_reg [0:QBITS];
    logic [DIFF_W-1:0]  mn_pipe_reg [0:QBITS];
    logic [COORD_W-1:0] md_pipe_reg [0:QBITS];
    logic [QBITS-1:0]   q_pipe_reg [0:QBITS];
    logic               neg_pipe_reg [0:QBITS];
    logic               ovf_pipe_reg [0:QBITS];

    // setup: quotient overflows 33 bits when the high numerator part reaches the divisor
    logic [DIFF_W-1:0] top_part;
    logic              ovf_next;
    assign top_part = mn_reg >> (QBITS - FRAC_BITS);
    assign ovf_next = top_part >= {1'b0, md_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]      <= ovf_next ? '0 : top_part[COORD_W-1:0];
            mn_pipe_reg[0]  <= mn_reg;
            md_pipe_reg[0]  <= md_reg;
            q_pipe_reg[0]   <= '0;
            neg_pipe_reg[0] <= neg_reg;
            ovf_pipe_reg[0] <= ovf_next;
        end
    end

    // restoring division, msb first
    for (genvar k = 1; k <= QBITS; k++) begin : g_bit
        localparam int BI = QBITS - k;
        logic              nbit;
        logic [DIFF_W-1:0] trial;
        logic              ge;

        if (BI >= FRAC_BITS) begin : g_num
            assign nbit = mn_pipe_reg[k-1][BI-FRAC_BITS];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        assign trial = {rem_reg[k-1], nbit};
        assign ge    = trial >= {1'b0, md_pipe_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]      <= ge ? COORD_W'(trial - {1'b0, md_pipe_reg[k-1]})
                                      : trial[COORD_W-1:0];
                mn_pipe_reg[k]  <= mn_pipe_reg[k-1];
                md_pipe_reg[k]  <= md_pipe_reg[k-1];
                q_pipe_reg[k]   <= q_pipe_reg[k-1] | (QBITS'(ge) << BI);
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
                ovf_pipe_reg[k] <= ovf_pipe_reg[k-1];
            end
        end
    end

    // sign and saturation
    logic [QBITS-1:0] q_fin;
    logic [QBITS-1:0] q_neg;
    coord_t           quot_next;
    coord_t           quot_reg;

    assign q_fin = q_pipe_reg[QBITS];
    assign q_neg = ~q_fin + QBITS'(1);

    always_comb begin
        if (ovf_pipe_reg[QBITS]) begin
            quot_next = neg_pipe_reg[QBITS] ? SAT_MIN : SAT_MAX;
        end else if (neg_pipe_reg[QBITS]) begin
            quot_next = (q_fin > QBITS'(33'h0_8000_0000)) ? SAT_MIN : coord_t'(q_neg[COORD_W-1:0]);
        end else begin
            quot_next = (q_fin > QBITS'(33'h0_7FFF_FFFF)) ? SAT_MAX : coord_t'(q_fin[COORD_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule
